// ===== rtl/slr_pkg.sv =====
`default_nettype none

package slr_pkg;

    // Field widths of the stream items
    localparam int ACT_W      = 3;
    localparam int CP_W       = 21;
    localparam int BG_W       = 25;
    localparam int ATTR_W     = 8;
    localparam int CWID_W     = 2;
    localparam int DELTA_W    = 12;
    localparam int IDX_W      = 10;
    localparam int COL_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int VIEW_W     = 11;
    localparam int COUNT_W    = 11;
    localparam int TOTAL_W    = 48;
    localparam int LW_W       = 9;
    localparam int MAXL_W     = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 25;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 136;

    // Actions
    localparam logic [ACT_W-1:0] ACT_PUSH   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_POP    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SCROLL = 3'd2;
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY_POP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_BG = 1'b1;

    localparam logic [MAXL_W-1:0] MAX_LINES_RESET = 11'd1024;
    localparam logic [CP_W-1:0]   SPACE_CP        = 21'h20;
    localparam logic [CWID_W-1:0] CW_SINGLE       = 2'd1;

    typedef enum logic [0:0] {
        S_IDLE,
        S_MEM
    } t_slr_state;

    // Stored cell word, codepoint in the low bits
    typedef struct packed {
        logic [CWID_W-1:0] cell_width;
        logic [ATTR_W-1:0] attributes;
        logic [BG_W-1:0]   background;
        logic [CP_W-1:0]   codepoint;
    } t_cell_word;

    typedef struct packed {
        logic [ACT_W-1:0]          action;
        logic [CP_W-1:0]           codepoint;
        logic [BG_W-1:0]           background;
        logic [ATTR_W-1:0]         attributes;
        logic [CWID_W-1:0]         cell_width;
        logic                      row_end;
        logic signed [DELTA_W-1:0] view_delta;
        logic                      alt_screen;
        logic [IDX_W-1:0]          line_index;
        logic [COL_W-1:0]          column;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VIEW_W-1:0]   view_offset;
        logic [COUNT_W-1:0]  line_count;
        logic [TOTAL_W-1:0]  total_lines;
        logic [LW_W-1:0]     line_width;
        logic [CP_W-1:0]     out_codepoint;
        logic [BG_W-1:0]     out_background;
        logic [ATTR_W-1:0]   out_attributes;
        logic [CWID_W-1:0]   out_cell_width;
    } t_result;

    typedef struct packed {
        logic take;
        logic load_direct;
        logic load_mem;
    } t_dp_cmd;

    typedef struct packed {
        logic needs_mem;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/slr_ctrl.sv =====
`default_nettype none

module slr_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  wire slr_pkg::t_dp_sts i_sts,
    output slr_pkg::t_dp_cmd     o_cmd
);
    import slr_pkg::*;

    t_slr_state r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        out_free    = !r_out_valid || i_out_ready;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = out_free;
                if (i_in_valid && out_free) begin
                    o_cmd.take = 1'b1;
                    if (i_sts.needs_mem) begin
                        n_state = S_MEM;
                    end else begin
                        o_cmd.load_direct = 1'b1;
                        n_out_valid       = 1'b1;
                    end
                end
            end
            S_MEM: begin
                // output register is empty here: it was free when the request was taken
                o_cmd.load_mem = 1'b1;
                n_out_valid    = 1'b1;
                n_state        = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/slr_datapath.sv =====
`default_nettype none

module slr_datapath #(
    parameter int RING_LINES = 1024,
    parameter int LINE_CELLS = 256
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire slr_pkg::t_item                   i_item,
    input  wire slr_pkg::t_dp_cmd                 i_cmd,
    output slr_pkg::t_dp_sts                      o_sts,
    input  wire logic                             i_cfg_valid,
    input  wire logic [slr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [slr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output slr_pkg::t_result                      o_result
);
    import slr_pkg::*;

    localparam int SW    = (RING_LINES > 1) ? $clog2(RING_LINES) : 1;
    localparam int PCW   = $clog2(LINE_CELLS + 1);
    localparam int CNTR  = $clog2(RING_LINES + 1);
    localparam int CNTW  = (CNTR > COUNT_W) ? CNTR : COUNT_W;
    localparam int DEPTH = RING_LINES * LINE_CELLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VW    = CNTW + 2;
    localparam logic [CNTW:0]   RING_SUM = (CNTW + 1)'(RING_LINES);
    localparam logic [CNTW-1:0] RING_CNT = CNTW'(RING_LINES);
    localparam logic [PCW-1:0]  CELLS_PC = PCW'(LINE_CELLS);

    // Storage
    t_cell_word           cell_store  [DEPTH];
    logic [PCW-1:0]       line_widths [RING_LINES];

    // Ring state and configuration
    logic [SW-1:0]        r_head, n_head;
    logic [CNTW-1:0]      r_count, n_count;
    logic [CNTW-1:0]      r_view, n_view;
    logic [TOTAL_W-1:0]   r_total, n_total;
    logic [PCW-1:0]       r_push_col, n_push_col;
    logic [PCW-1:0]       r_kept, n_kept;
    logic [MAXL_W-1:0]    r_max_lines;
    logic [BG_W-1:0]      r_def_bg;

    // Read-back registers
    logic [PCW-1:0]       r_lw_rd;
    t_cell_word           r_cell_rd;
    logic [COL_W-1:0]     r_rd_col;
    logic                 r_rd_is_read;
    t_result              r_result;

    logic [CNTW-1:0]      cap;
    logic [CNTW:0]        tail_sum, idx_sum;
    logic [SW-1:0]        tail_slot, newest_slot, idx_slot, lw_rd_slot, head_inc;
    logic [PCW-1:0]       col_inc, col_after, row_width;
    logic                 plain, cell_we, lw_we, rd_en;
    logic [AW-1:0]        wr_addr, rd_addr;
    logic signed [VW-1:0] v_sum;
    logic [STATUS_W-1:0]  d_status;
    t_cell_word           wdata;
    t_result              direct_res, mem_res;

    function automatic logic [SW-1:0] wrap_slot(input logic [CNTW:0] s);
        logic [CNTW:0] w;
        begin
            w = (s >= RING_SUM) ? s - RING_SUM : s;
            return w[SW-1:0];
        end
    endfunction

    always_comb begin
        cap = (CNTW'(r_max_lines) >= RING_CNT) ? RING_CNT : CNTW'(r_max_lines);

        tail_sum    = (CNTW + 1)'(r_head) + (CNTW + 1)'(r_count);
        idx_sum     = (CNTW + 1)'(r_head) + (CNTW + 1)'(i_item.line_index);
        tail_slot   = wrap_slot(tail_sum);
        newest_slot = wrap_slot(tail_sum - 1'b1);
        idx_slot    = wrap_slot(idx_sum);
        head_inc    = (r_head == SW'(RING_LINES - 1)) ? '0 : r_head + 1'b1;
        lw_rd_slot  = (i_item.action == ACT_POP) ? newest_slot : idx_slot;

        wdata.codepoint  = i_item.codepoint;
        wdata.background = i_item.background;
        wdata.attributes = i_item.attributes;
        wdata.cell_width = i_item.cell_width;
        plain = (i_item.codepoint == SPACE_CP) && (i_item.background == r_def_bg) &&
                (i_item.attributes == '0) && (i_item.cell_width == CW_SINGLE);

        wr_addr = AW'(tail_slot) * AW'(LINE_CELLS) + AW'(r_push_col);
        rd_addr = AW'(idx_slot) * AW'(LINE_CELLS) +
                  ((32'(i_item.column) < LINE_CELLS) ? AW'(i_item.column) : '0);

        col_inc   = r_push_col + 1'b1;
        col_after = r_push_col;
        row_width = r_kept;
        if (r_push_col < CELLS_PC) begin
            col_after = col_inc;
            if (!plain) begin
                row_width = col_inc;
            end
        end

        v_sum = $signed(VW'(r_view)) + VW'(i_item.view_delta);

        n_head      = r_head;
        n_count     = r_count;
        n_view      = r_view;
        n_total     = r_total;
        n_push_col  = '0;
        n_kept      = '0;
        cell_we     = 1'b0;
        lw_we       = 1'b0;
        d_status    = ST_OK;
        o_sts       = '0;

        case (i_item.action)
            ACT_PUSH: begin
                cell_we = i_cmd.take && (r_push_col < CELLS_PC);
                if (i_item.row_end) begin
                    n_total = r_total + 1'b1;
                    if (cap != '0) begin
                        lw_we = i_cmd.take;
                        if (r_count < cap) begin
                            n_count = r_count + 1'b1;
                            if (r_view != '0) begin
                                n_view = r_view + 1'b1;
                            end
                        end else begin
                            n_head = head_inc;
                        end
                    end
                end else begin
                    n_push_col = col_after;
                    n_kept     = row_width;
                end
            end
            ACT_POP: begin
                if (r_count == '0) begin
                    d_status = ST_EMPTY_POP;
                end else begin
                    o_sts.needs_mem = 1'b1;
                    n_count         = r_count - 1'b1;
                    n_total         = r_total - 1'b1;
                end
            end
            ACT_SCROLL: begin
                if (i_item.alt_screen) begin
                    n_view = '0;
                end else if (v_sum < 0) begin
                    n_view = '0;
                end else if (v_sum > $signed(VW'(r_count))) begin
                    n_view = r_count;
                end else begin
                    n_view = v_sum[CNTW-1:0];
                end
            end
            ACT_READ: begin
                if (CNTW'(i_item.line_index) >= r_count) begin
                    d_status = ST_BAD_INDEX;
                end else begin
                    o_sts.needs_mem = 1'b1;
                end
            end
            ACT_CLEAR: begin
                n_head  = '0;
                n_count = '0;
                n_view  = '0;
            end
            default: ;
        endcase

        if (n_view > n_count) begin
            n_view = n_count;
        end

        rd_en = i_cmd.take && o_sts.needs_mem;

        direct_res             = '0;
        direct_res.status      = d_status;
        direct_res.view_offset = VIEW_W'(n_view);
        direct_res.line_count  = COUNT_W'(n_count);
        direct_res.total_lines = n_total;

        mem_res             = '0;
        mem_res.status      = ST_OK;
        mem_res.view_offset = VIEW_W'(r_view);
        mem_res.line_count  = COUNT_W'(r_count);
        mem_res.total_lines = r_total;
        mem_res.line_width  = LW_W'(r_lw_rd);
        if (r_rd_is_read) begin
            if (32'(r_rd_col) < 32'(r_lw_rd)) begin
                mem_res.out_codepoint  = r_cell_rd.codepoint;
                mem_res.out_background = r_cell_rd.background;
                mem_res.out_attributes = r_cell_rd.attributes;
                mem_res.out_cell_width = r_cell_rd.cell_width;
            end else begin
                mem_res.out_codepoint  = SPACE_CP;
                mem_res.out_background = r_def_bg;
                mem_res.out_attributes = '0;
                mem_res.out_cell_width = CW_SINGLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_view      <= '0;
            r_total     <= '0;
            r_push_col  <= '0;
            r_kept      <= '0;
            r_max_lines <= MAX_LINES_RESET;
            r_def_bg    <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MAX_LINES:  r_max_lines <= i_cfg_data[MAXL_W-1:0];
                    CFG_DEFAULT_BG: r_def_bg    <= i_cfg_data[BG_W-1:0];
                endcase
            end
            if (i_cmd.take) begin
                r_head     <= n_head;
                r_count    <= n_count;
                r_view     <= n_view;
                r_total    <= n_total;
                r_push_col <= n_push_col;
                r_kept     <= n_kept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cell_we) begin
            cell_store[wr_addr] <= wdata;
        end
        if (lw_we) begin
            line_widths[tail_slot] <= row_width;
        end
        if (rd_en) begin
            r_lw_rd   <= line_widths[lw_rd_slot];
            r_cell_rd <= cell_store[rd_addr];
        end
        if (i_cmd.take) begin
            r_rd_col     <= i_item.column;
            r_rd_is_read <= (i_item.action == ACT_READ);
        end
        if (i_cmd.load_direct) begin
            r_result <= direct_res;
        end else if (i_cmd.load_mem) begin
            r_result <= mem_res;
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== rtl/scrollback_line_ring.sv =====
`default_nettype none

// Channel    Direction  Handshake                      Payload
// s_axis     in         i_s_axis_tvalid/o_s_axis_tready tdata cell and control fields,
//                                                      tlast row_end, tuser action
// m_axis     out        o_m_axis_tvalid/i_m_axis_tready tdata result fields, tuser status
// cfg        in         i_cfg_valid/o_cfg_ready         i_cfg_index, i_cfg_data
//
// Sequencing: push, scroll, clear, empty pop and out-of-range read load the result direct
// and may follow back to back while results are taken; a pop or in-range read also passes
// through S_MEM, for the registered read port of the cell store and line width store.
// Reset clears the ring pointers, counters and output valid at once; the stores need
// no clearing pass, since only entries written by a finished row are ever read.
// Stalls: the output register holds a result until taken; a new request is taken in
// the same cycle the old result leaves. Configuration writes are always taken.

module scrollback_line_ring #(
    parameter int RING_LINES = 1024,
    parameter int LINE_CELLS = 256
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // slave stream
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // [20:0] codepoint, [45:21] background, [53:46] attributes, [55:54] cell_width,
    // [67:56] view_delta, [68] alt_screen, [78:69] line_index, [86:79] column, [87] zero
    input  wire logic [slr_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    input  wire logic                               i_s_axis_tlast,
    // [2:0] action
    input  wire logic [slr_pkg::ACT_W-1:0]          i_s_axis_tuser,
    // master stream
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // [10:0] view_offset, [21:11] line_count, [69:22] total_lines, [78:70] line_width,
    // [99:79] out_codepoint, [124:100] out_background, [132:125] out_attributes,
    // [134:133] out_cell_width, [135] zero
    output logic [slr_pkg::OUT_TDATA_W-1:0]         o_m_axis_tdata,
    // [1:0] status
    output logic [slr_pkg::STATUS_W-1:0]            o_m_axis_tuser,
    // configuration writes
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [slr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [slr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import slr_pkg::*;

    t_item   item;
    t_result res;
    t_dp_cmd cmd;
    t_dp_sts sts;

    // Unpack the request
    assign item.action      = i_s_axis_tuser;
    assign item.codepoint   = i_s_axis_tdata[20:0];
    assign item.background  = i_s_axis_tdata[45:21];
    assign item.attributes  = i_s_axis_tdata[53:46];
    assign item.cell_width  = i_s_axis_tdata[55:54];
    assign item.view_delta  = $signed(i_s_axis_tdata[67:56]);
    assign item.alt_screen  = i_s_axis_tdata[68];
    assign item.line_index  = i_s_axis_tdata[78:69];
    assign item.column      = i_s_axis_tdata[86:79];
    assign item.row_end     = i_s_axis_tlast;

    // Configuration writes never stall
    assign o_cfg_ready = 1'b1;

    slr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    slr_datapath #(
        .RING_LINES (RING_LINES),
        .LINE_CELLS (LINE_CELLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (res)
    );

    // Pack the result, first field lowest
    assign o_m_axis_tdata = {1'b0, res.out_cell_width, res.out_attributes,
                             res.out_background, res.out_codepoint, res.line_width,
                             res.total_lines, res.line_count, res.view_offset};
    assign o_m_axis_tuser = res.status;

endmodule

`default_nettype wire

// ===== rtl/slr_checker.sv =====
`default_nettype none

module slr_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               o_m_axis_tvalid,
    input wire logic                               i_m_axis_tready,
    input wire logic [slr_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    input wire logic [slr_pkg::STATUS_W-1:0]       o_m_axis_tuser
);
    import slr_pkg::*;

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // Reset drops any pending result
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // View never scrolls past the lines held
    a_view: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[10:0] <= o_m_axis_tdata[21:11])
        else $error("view offset beyond line count");

    // Empty pop reports an empty ring and no width
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ST_EMPTY_POP |->
            o_m_axis_tdata[21:11] == '0 && o_m_axis_tdata[78:70] == '0)
        else $error("empty pop with lines held");

endmodule

bind scrollback_line_ring slr_checker u_slr_checker (.*);

`default_nettype wire
